// ----- hw/rtl/jrpf_pkg.sv -----
package jrpf_pkg;

  localparam int unsigned TableBytes = 64;
  localparam int unsigned AllTables  = 2 * TableBytes;
  localparam int unsigned MinLimit   = 8 + 4 + AllTables + 1;
  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] MinLimitW  = 16'(MinLimit);
  localparam logic [7:0]  AllTablesW = 8'(AllTables);

  localparam logic [7:0] QFirst = 8'd128;
  localparam logic [7:0] QLater = 8'd96;

  // header lengths in bytes, data byte follows at this index
  localparam logic [3:0] HdrLenNone  = 4'd0;
  localparam logic [3:0] HdrLenFirst = 4'd12;
  localparam logic [3:0] HdrLenLater = 4'd8;

  localparam logic [15:0] FillFirst = 16'd12;
  localparam logic [15:0] FillLater = 16'd8;

  // configuration register indexes
  localparam logic [1:0] RegMaxPayload = 2'd0;
  localparam logic [1:0] RegWidth      = 2'd1;
  localparam logic [1:0] RegHeight     = 2'd2;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_FIRST,
    HDR_LATER
  } hdr_e;

  // one classified input byte, as handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    hdr_e        hdr;
    logic [23:0] offset;
    logic        pkt_end;
    logic        marker;
  } cmd_t;

  function automatic logic [3:0] hdr_len(hdr_e kind);
    logic [3:0] len;
    unique case (kind)
      HDR_FIRST: len = HdrLenFirst;
      HDR_LATER: len = HdrLenLater;
      default:   len = HdrLenNone;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hdr_byte(hdr_e kind, logic [3:0] idx, logic [23:0] off,
                                          logic [7:0] wb, logic [7:0] hb);
    logic [7:0] b;
    b = 8'h00;
    if (kind == HDR_FIRST) begin
      unique case (idx)
        4'd5:    b = QFirst;
        4'd6:    b = wb;
        4'd7:    b = hb;
        4'd10:   b = 8'(AllTables >> 8);
        4'd11:   b = 8'(AllTables & 8'hff);
        default: b = 8'h00;
      endcase
    end else begin
      unique case (idx)
        4'd1:    b = off[23:16];
        4'd2:    b = off[15:8];
        4'd3:    b = off[7:0];
        4'd5:    b = QLater;
        4'd6:    b = wb;
        4'd7:    b = hb;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/jrpf_front.sv -----
module jrpf_front import jrpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic [15:0] max_payload_i,
  output cmd_t        cmd_o
);

  logic [7:0]  seen_q, seen_d;
  logic [15:0] fill_q, fill_d;
  logic [23:0] offset_q, offset_d;
  logic        open_q, open_d;
  logic        first_q, first_d;

  logic [15:0] limit;
  logic [15:0] fill_base;
  logic [15:0] fill_new;
  logic        full_pkt;

  assign limit     = (max_payload_i < MinLimitW) ? MinLimitW : max_payload_i;
  assign fill_base = open_q ? fill_q : (first_q ? FillFirst : FillLater);
  assign fill_new  = fill_base + 16'd1;
  assign full_pkt  = fill_new >= limit;

  always_comb begin
    cmd_o.data    = data_byte_i;
    cmd_o.hdr     = open_q ? HDR_NONE : (first_q ? HDR_FIRST : HDR_LATER);
    cmd_o.offset  = offset_q;
    cmd_o.pkt_end = frame_end_i | full_pkt;
    cmd_o.marker  = frame_end_i;
  end

  always_comb begin
    seen_d   = seen_q;
    offset_d = offset_q;
    fill_d   = fill_q;
    open_d   = open_q;
    first_d  = first_q;
    if (accept_i) begin
      if (seen_q < AllTablesW) begin
        seen_d = seen_q + 8'd1;
      end else begin
        offset_d = offset_q + 24'd1;
      end
      if (frame_end_i) begin
        seen_d   = '0;
        offset_d = '0;
        fill_d   = '0;
        open_d   = 1'b0;
        first_d  = 1'b1;
      end else if (full_pkt) begin
        fill_d  = '0;
        open_d  = 1'b0;
        first_d = 1'b0;
      end else begin
        fill_d = fill_new;
        open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      fill_q   <= '0;
      offset_q <= '0;
      open_q   <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      seen_q   <= seen_d;
      fill_q   <= fill_d;
      offset_q <= offset_d;
      open_q   <= open_d;
      first_q  <= first_d;
    end
  end

endmodule

// ----- hw/rtl/jrpf_queue.sv -----
module jrpf_queue import jrpf_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = cnt_q == CntW'(DEPTH);
  assign empty_o   = cnt_q == '0;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/jrpf_back.sv -----
module jrpf_back import jrpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  input  logic [7:0] width_blocks_i,
  input  logic [7:0] height_blocks_i,
  output logic [7:0] out_byte_o,
  output logic       packet_start_o,
  output logic       packet_end_o,
  output logic       marker_o,
  output logic       run_last_o,
  output logic       empty,
  input  logic       pop
);

  logic [3:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic [7:0] byte_q;
  logic       start_q, end_q, marker_q, last_q;

  logic [3:0] len;
  logic       last;
  logic       advance;
  logic [7:0] cur_byte;

  assign len      = hdr_len(cmd_i.hdr);
  assign last     = idx_q == len;
  assign advance  = !cmd_empty_i && (!ov_q || pop);
  assign cur_byte = last ? cmd_i.data
                         : hdr_byte(cmd_i.hdr, idx_q, cmd_i.offset, width_blocks_i,
                                    height_blocks_i);
  assign cmd_pop_o = advance && last;

  always_comb begin
    idx_d = idx_q;
    ov_d  = ov_q;
    if (advance) begin
      idx_d = last ? 4'd0 : idx_q + 4'd1;
      ov_d  = 1'b1;
    end else if (pop) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q   <= cur_byte;
      start_q  <= (idx_q == 4'd0) && (cmd_i.hdr != HDR_NONE);
      end_q    <= last && cmd_i.pkt_end;
      marker_q <= last && cmd_i.marker;
      last_q   <= last;
    end
  end

  assign empty          = !ov_q;
  assign out_byte_o     = byte_q;
  assign packet_start_o = start_q;
  assign packet_end_o   = end_q;
  assign marker_o       = marker_q;
  assign run_last_o     = last_q;

endmodule

// ----- hw/rtl/jpeg_rtp_payload_framer.sv -----
// jpeg rtp payload framer: takes one frame a byte at a time (128 quantization
// table bytes, then scan bytes, frame_end on the last byte) and emits the
// rfc 2435 payload byte stream with packet start/end flags and the marker on
// the frame's last byte. the first packet carries the main header with q=128,
// the table header and both tables; later packets carry a q=96 header with
// the 24-bit scan offset. packets are cut at max_payload_size, header
// included, with a floor of 141 bytes. a byte that continues an open packet
// costs one output beat; a byte that opens the frame's first packet costs 13
// beats, one that opens a later packet 9. the back end drives one beat per
// cycle through its output register while pop keeps up, so that register
// sets the throughput; the front end takes one byte per cycle into a short
// command queue, so header bursts show up as brief full stalls on the input
// side. configuration takes effect immediately; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module jpeg_rtp_payload_framer import jrpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input side, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  // result side, queue style
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        packet_end_o,
  output logic        marker_o,
  output logic        run_last_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] max_payload_q;
  logic [7:0]  width_blocks_q;
  logic [7:0]  height_blocks_q;

  logic accept;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_empty;
  logic head_pop;

  // config writes always land at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q   <= 16'd1400;
      width_blocks_q  <= 8'd40;
      height_blocks_q <= 8'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMaxPayload: max_payload_q   <= cfg_data_i;
        RegWidth:      width_blocks_q  <= cfg_data_i[7:0];
        RegHeight:     height_blocks_q <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  // an input beat is taken whenever the command queue has room
  assign accept = push && !full;

  // front: tracks table/scan position and packet fill, tags each byte
  jrpf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .max_payload_i (max_payload_q),
    .cmd_o         (front_cmd)
  );

  // decouples byte intake from header expansion
  jrpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_en_i   (head_pop),
    .rd_data_o (head_cmd),
    .empty_o   (head_empty)
  );

  // back: expands headers and drives one beat per cycle while pop keeps up
  jrpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (head_cmd),
    .cmd_empty_i     (head_empty),
    .cmd_pop_o       (head_pop),
    .width_blocks_i  (width_blocks_q),
    .height_blocks_i (height_blocks_q),
    .out_byte_o      (out_byte_o),
    .packet_start_o  (packet_start_o),
    .packet_end_o    (packet_end_o),
    .marker_o        (marker_o),
    .run_last_o      (run_last_o),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

// ----- hw/rtl/jrpf_checker.sv -----
module jrpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte_o,
  input logic        packet_start_o,
  input logic        packet_end_o,
  input logic        marker_o,
  input logic        run_last_o
);

  // the marker only sits on a packet's closing beat
  a_marker_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && marker_o |-> packet_end_o)
    else $error("marker without packet end");

  // a packet closes on a data byte, which is the last beat of its run
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && packet_end_o |-> run_last_o)
    else $error("packet end not on last beat of run");

  // every packet opens with the zero type-specific header byte
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && packet_start_o |-> out_byte_o == 8'h00 && !run_last_o)
    else $error("packet start not on a zero header byte");

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_byte_o) && $stable(packet_end_o))
    else $error("waiting beat changed");

endmodule

bind jpeg_rtp_payload_framer jrpf_checker u_jrpf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .out_byte_o     (out_byte_o),
  .packet_start_o (packet_start_o),
  .packet_end_o   (packet_end_o),
  .marker_o       (marker_o),
  .run_last_o     (run_last_o)
);
